/* rtl/core/mse_pkg.sv */
`default_nettype none

package mse_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH) + 1;

endpackage

`default_nettype wire

/* rtl/core/merge_sort_engine_top.sv */
// Load: one item per cycle into the element memory; s_tready stays high meanwhile.
// Sort: ceil(log2(n)) merge passes ping-ponging between two 1-port-read memories,
//   each pass reads the heads of each pair of runs (PRIME_A, PRIME_B), then merges one element per cycle.
// Emit: per result a memory read (EMIT_RD), then the output register (EMIT_WR); EMIT_RD waits
//   until the output register is free or being taken, so only one result is held at a time.
// Reset clears count, overflow flag, state and output valid; memories are not cleared.
`default_nettype none

module merge_sort_engine_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [mse_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
  input  wire logic                      s_tlast,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [mse_pkg::DATA_W-1:0]     m_tdata,   // [31:0] sorted_value
  output logic                           m_tlast,
  output logic                           m_tuser    // [0] overflow
);

  localparam int CW = mse_pkg::CNT_W;
  localparam int IW = mse_pkg::IDX_W;
  localparam int DW = mse_pkg::DATA_W;

  typedef enum logic [6:0] {
    ST_LOAD    = 7'b0000001,
    ST_PASS    = 7'b0000010,
    ST_PRIME_A = 7'b0000100,
    ST_PRIME_B = 7'b0001000,
    ST_RUN     = 7'b0010000,
    ST_EMIT_RD = 7'b0100000,
    ST_EMIT_WR = 7'b1000000
  } state_t;

  state_t state;

  logic [DW-1:0] mem0 [mse_pkg::DEPTH];
  logic [DW-1:0] mem1 [mse_pkg::DEPTH];
  logic [DW-1:0] rd0, rd1;

  logic [CW-1:0] count, w, lo, mid, hi, a, b, k, idx;
  logic          dropped, src_sel, refill_a, refill_b;
  logic [DW-1:0] head_a, head_b;

  logic [DW-1:0] rdata, cur_a, cur_b, win, wdata;
  logic          a_done, b_done, take_a;
  logic          s_accept, has_room, we0, we1, emit_last;
  logic [CW-1:0] count_inc, n_next, mid_c, hi_c, k_inc, a_inc, b_inc, idx_inc;
  logic [CW:0]   mid_sum, hi_sum;
  logic [IW-1:0] rd_addr, wr_addr;

  assign s_tready  = (state == ST_LOAD);
  assign s_accept  = s_tvalid && s_tready;
  assign has_room  = (count < CW'(mse_pkg::DEPTH));
  assign count_inc = count + CW'(1);
  assign n_next    = has_room ? count_inc : count;

  assign rdata  = src_sel ? rd1 : rd0;
  assign cur_a  = refill_a ? rdata : head_a;
  assign cur_b  = refill_b ? rdata : head_b;
  assign a_done = (a == mid);
  assign b_done = (b == hi);
  assign take_a = !a_done && (b_done || ($signed(cur_a) < $signed(cur_b)));
  assign win    = take_a ? cur_a : cur_b;

  assign mid_sum = {1'b0, lo} + {1'b0, w};
  assign hi_sum  = {1'b0, lo} + {w, 1'b0};
  assign mid_c   = (mid_sum > {1'b0, count}) ? count : mid_sum[CW-1:0];
  assign hi_c    = (hi_sum > {1'b0, count}) ? count : hi_sum[CW-1:0];

  assign k_inc   = k + CW'(1);
  assign a_inc   = a + CW'(1);
  assign b_inc   = b + CW'(1);
  assign idx_inc = idx + CW'(1);
  assign emit_last = (idx_inc == count);

  always_comb begin
    unique case (state)
      ST_PRIME_A: rd_addr = lo[IW-1:0];
      ST_PRIME_B: rd_addr = mid[IW-1:0];
      ST_RUN:     rd_addr = take_a ? a_inc[IW-1:0] : b_inc[IW-1:0];
      ST_EMIT_RD: rd_addr = idx[IW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  // load writes mem0; a merge pass writes the memory it does not read
  assign we0     = (s_accept && has_room) || ((state == ST_RUN) && src_sel);
  assign we1     = (state == ST_RUN) && !src_sel;
  assign wr_addr = (state == ST_RUN) ? k[IW-1:0] : count[IW-1:0];
  assign wdata   = (state == ST_RUN) ? win : s_tdata;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= wdata;
    end
    rd0 <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wr_addr] <= wdata;
    end
    rd1 <= mem1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if ((state == ST_PRIME_B) || (state == ST_RUN)) begin
      head_a <= cur_a;
      head_b <= cur_b;
    end
    if (state == ST_EMIT_WR) begin
      m_tdata <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      dropped  <= 1'b0;
      w        <= '0;
      lo       <= '0;
      mid      <= '0;
      hi       <= '0;
      a        <= '0;
      b        <= '0;
      k        <= '0;
      idx      <= '0;
      src_sel  <= 1'b0;
      refill_a <= 1'b0;
      refill_b <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      m_tuser  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (s_accept) begin
            count <= n_next;
            if (!has_room) begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              w       <= CW'(1);
              src_sel <= 1'b0;
              state   <= ST_PASS;
            end
          end
        end
        ST_PASS: begin
          if (w >= count) begin
            idx   <= '0;
            state <= ST_EMIT_RD;
          end else begin
            lo    <= '0;
            state <= ST_PRIME_A;
          end
        end
        ST_PRIME_A: begin
          mid      <= mid_c;
          hi       <= hi_c;
          a        <= lo;
          b        <= mid_c;
          k        <= lo;
          refill_a <= 1'b1;
          refill_b <= 1'b0;
          state    <= ST_PRIME_B;
        end
        ST_PRIME_B: begin
          refill_a <= 1'b0;
          refill_b <= 1'b1;
          state    <= ST_RUN;
        end
        ST_RUN: begin
          k        <= k_inc;
          refill_a <= take_a;
          refill_b <= !take_a;
          if (take_a) begin
            a <= a_inc;
          end else begin
            b <= b_inc;
          end
          if (k_inc == hi) begin
            lo <= hi;
            if (hi >= count) begin
              w       <= {w[CW-2:0], 1'b0};
              src_sel <= !src_sel;
              state   <= ST_PASS;
            end else begin
              state <= ST_PRIME_A;
            end
          end
        end
        ST_EMIT_RD: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_EMIT_WR;
          end
        end
        ST_EMIT_WR: begin
          m_tvalid <= 1'b1;
          m_tlast  <= emit_last;
          m_tuser  <= dropped;
          idx      <= idx_inc;
          if (emit_last) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= ST_LOAD;
          end else begin
            state <= ST_EMIT_RD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mse_pkg::DEPTH))
    else $error("element count above capacity");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (k < hi) && (a <= mid) && (b <= hi))
    else $error("merge pointers out of range");

  a_run_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (k == CW'(a + b - mid)))
    else $error("merge write pointer out of step with read pointers");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_WR) |-> !m_tvalid)
    else $error("output register overwritten while holding an item");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [mse_pkg::DATA_W-1:0] value;
    logic                       last;
    logic                       overflow;
  } sorted_item_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [mse_pkg::DATA_W-1:0] s_tdata  = '0;
  logic                       s_tlast  = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [mse_pkg::DATA_W-1:0] m_tdata;
  logic                       m_tlast;
  logic                       m_tuser;

  logic signed [mse_pkg::DATA_W-1:0] block_vals[$];
  logic                              block_dropped = 1'b0;
  sorted_item_t                      sorted_expect[$];
  int                                err_count = 0;
  bit                                idle_en = 1'b1;
  int                                stall_left = 0;

  merge_sort_engine_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // collect the block; on the last item sort it and queue one result per stored value
  task automatic predict_sorted(input logic [mse_pkg::DATA_W-1:0] v, input logic l);
    logic signed [mse_pkg::DATA_W-1:0] held;
    sorted_item_t                      r;
    int                                i;
    int                                j;
    if (block_vals.size() < mse_pkg::DEPTH) begin
      block_vals.push_back(v);
    end else begin
      block_dropped = 1'b1;
    end
    if (l) begin
      for (i = 1; i < block_vals.size(); i++) begin
        held = block_vals[i];
        j = i - 1;
        while (j >= 0 && block_vals[j] > held) begin
          block_vals[j + 1] = block_vals[j];
          j--;
        end
        block_vals[j + 1] = held;
      end
      for (i = 0; i < block_vals.size(); i++) begin
        r.value    = block_vals[i];
        r.last     = (i == block_vals.size() - 1);
        r.overflow = block_dropped;
        sorted_expect.push_back(r);
      end
      block_vals.delete();
      block_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input logic [mse_pkg::DATA_W-1:0] v, input logic l);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    predict_sorted(v, l);
  endtask

  function automatic logic [mse_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: rand_value = $urandom_range(0, 15) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: rand_value = 32'h8000_0000;
          1: rand_value = 32'h7fff_ffff;
          2: rand_value = 32'h0000_0000;
          default: rand_value = 32'hffff_ffff;
        endcase
      end
      default: rand_value = $urandom;
    endcase
  endfunction

  task automatic send_block(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_item(rand_value(), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (sorted_expect.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_extremes();
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7fff_ffff, 1'b1);
  endtask

  task automatic test_mixed_extremes();
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b1);
  endtask

  task automatic test_ties();
    send_item(32'd7, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b0);
    send_item(-32'sd3, 1'b1);
  endtask

  task automatic test_presorted();
    int i;
    for (i = 0; i < 4; i++) send_item(i * 1000 - 1500, i == 3);
    for (i = 0; i < 4; i++) send_item(32'h7000_0000 - i * 32'h1111_1111, i == 3);
  endtask

  task automatic test_full_store();
    send_block(mse_pkg::DEPTH);
  endtask

  // last item lands after the store is full, so it is dropped but still ends the block
  task automatic test_overflow();
    send_block(mse_pkg::DEPTH + 1);
    send_block($urandom_range(mse_pkg::DEPTH + 2, mse_pkg::DEPTH + 8));
  endtask

  task automatic test_random_blocks(input int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      n = $urandom_range(1, 6);
      send_block(n);
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_expect.size() == 0) begin
        $display("%0t: unexpected item expected none actual %h last %b ovf %b",
                 $time, m_tdata, m_tlast, m_tuser);
        err_count++;
      end else begin
        if (m_tdata !== sorted_expect[0].value) begin
          $display("%0t: value expected %h actual %h", $time,
                   sorted_expect[0].value, m_tdata);
          err_count++;
        end
        if (m_tlast !== sorted_expect[0].last) begin
          $display("%0t: last expected %b actual %b", $time,
                   sorted_expect[0].last, m_tlast);
          err_count++;
        end
        if (m_tuser !== sorted_expect[0].overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   sorted_expect[0].overflow, m_tuser);
          err_count++;
        end
        void'(sorted_expect.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_extremes();
    test_mixed_extremes();
    test_ties();
    test_presorted();
    s_tvalid <= 1'b0;
    wait_drained();
    test_full_store();
    test_overflow();
    test_random_blocks(8);
    idle_en = 1'b0;
    test_random_blocks(4);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (400) @(posedge clk);
    if (err_count == 0 && sorted_expect.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
